// File: hdl/fpsc_pkg.sv
// Shared constants and controller/datapath handshake types for the fractional
// PLL setting calculator. No dependencies.
package fpsc_pkg;

    localparam int PCLK_W    = 20;
    localparam int REF_W     = 20;
    localparam int WORD_W    = 32;
    localparam int MULT_W    = 24;
    localparam int NDIV_W    = 8;
    localparam int OD_W      = 5;
    localparam int FRAC_W    = 18;

    // internal widths: N never exceeds 21, OD never exceeds 18
    localparam int N_W       = 5;
    localparam int VCO_W     = PCLK_W + FRAC_W;
    localparam int PROD_W    = 24;
    localparam int DIVD_W    = PROD_W + FRAC_W;
    localparam int DCNT_W    = $clog2(DIVD_W);

    localparam logic [REF_W-1:0]  REF_RESET   = 20'd33333;
    localparam logic [REF_W-1:0]  REF_MIN_DIV = 20'd5000;
    localparam logic [REF_W-1:0]  REF_MAX_DIV = 20'd50000;
    localparam logic [PCLK_W-1:0] VCO_MIN     = 20'd200000;
    localparam logic [PCLK_W-1:0] VCO_MAX     = 20'd700000;
    localparam logic [N_W-1:0]    N_INIT      = 5'd4;
    localparam logic [OD_W-1:0]   OD_INIT     = 5'd2;

    localparam int FRAC_SHIFT = 14;
    localparam int OD_SHIFT   = 12;
    localparam int N_SHIFT    = 8;

    typedef struct packed {
        logic load_in;
        logic set_err;
        logic n_step;
        logic od_step;
        logic div_load;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic bad;
        logic n_lo;
        logic n_hi;
        logic od_lo;
        logic od_hi;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

// File: hdl/fpsc_ifs.sv
// Valid/ready channel interfaces: configuration write, request, result.
// Depends on fpsc_pkg.
interface fpsc_cfg_if;
    import fpsc_pkg::*;
    logic              valid;
    logic              ready;
    logic [REF_W-1:0]  ref_clk_khz;
    modport source (output valid, output ref_clk_khz, input ready);
    modport sink (input valid, input ref_clk_khz, output ready);
endinterface

interface fpsc_req_if;
    import fpsc_pkg::*;
    logic              valid;
    logic              ready;
    logic [PCLK_W-1:0] pixel_clk_khz;
    modport source (output valid, output pixel_clk_khz, input ready);
    modport sink (input valid, input pixel_clk_khz, output ready);
endinterface

interface fpsc_res_if;
    import fpsc_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] pll_word;
    logic [MULT_W-1:0] mult_int;
    logic [NDIV_W-1:0] pre_div;
    logic [OD_W-1:0]   out_div_exp;
    logic [FRAC_W-1:0] frac_part;
    logic              range_error;
    modport source (output valid, output pll_word, output mult_int, output pre_div,
                    output out_div_exp, output frac_part, output range_error,
                    input ready);
    modport sink (input valid, input pll_word, input mult_int, input pre_div,
                  input out_div_exp, input frac_part, input range_error,
                  output ready);
endinterface

// File: hdl/fpsc_ctrl.sv
// Sequencing state machine: range check, divider searches, long division,
// result hand-off. Depends on fpsc_pkg.
module fpsc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fpsc_pkg::dp_status_t status,
    output fpsc_pkg::dp_cmd_t    cmd
);
    import fpsc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_NSRCH  = 6'b000100,
        S_OSRCH  = 6'b001000,
        S_DIV    = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.bad)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                    state_next = S_NSRCH;
            end
            S_NSRCH:
            begin
                cmd.n_step = 1'b1;
                if (!status.n_lo && !status.n_hi)
                    state_next = S_OSRCH;
            end
            S_OSRCH:
            begin
                cmd.od_step = 1'b1;
                if (!status.od_lo && !status.od_hi)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: hdl/fpsc_dp.sv
// Datapath: reference register, N/OD search registers, restoring divider and
// result output register. Depends on fpsc_pkg.
module fpsc_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fpsc_pkg::dp_cmd_t            cmd,
    output fpsc_pkg::dp_status_t         status,
    input  logic                         cfg_valid,
    input  logic [fpsc_pkg::REF_W-1:0]   cfg_data,
    input  logic [fpsc_pkg::PCLK_W-1:0]  req_pclk,
    input  logic                         res_ready,
    output logic                         res_valid,
    output logic [fpsc_pkg::WORD_W-1:0]  res_word,
    output logic [fpsc_pkg::MULT_W-1:0]  res_mult,
    output logic [fpsc_pkg::NDIV_W-1:0]  res_ndiv,
    output logic [fpsc_pkg::OD_W-1:0]    res_od,
    output logic [fpsc_pkg::FRAC_W-1:0]  res_frac,
    output logic                         res_err
);
    import fpsc_pkg::*;

    logic [REF_W-1:0]  ref_reg;
    logic [PCLK_W-1:0] pclk_reg;
    logic [N_W-1:0]    n_reg;
    logic [OD_W-1:0]   od_reg;
    logic              err_reg;
    logic [REF_W-1:0]  rem_reg, rem_next;
    logic [DIVD_W-1:0] dq_reg, dq_next;
    logic [DCNT_W-1:0] cnt_reg;
    logic              out_valid_reg;

    logic [REF_W:0]    n_lo_lim, n_hi_lim;
    logic [VCO_W-1:0]  vco;
    logic [24:0]       pn;
    logic [DIVD_W:0]   prod_wide;
    logic [REF_W:0]    trial;
    logic              q_bit;
    logic [WORD_W-1:0] word;

    // floor(ref/n) < 5000 <=> ref < 5000n; floor(ref/n) > 50000 <=> ref >= 50001n
    assign n_lo_lim = (REF_W+1)'(REF_MIN_DIV) * (REF_W+1)'(n_reg);
    assign n_hi_lim = (REF_W+1)'(REF_MAX_DIV + 20'd1) * (REF_W+1)'(n_reg);
    assign vco      = VCO_W'(pclk_reg) << od_reg;

    // pclk*N*NO stays below 2^24 once both searches have settled
    assign pn        = 25'(pclk_reg) * 25'(n_reg);
    assign prod_wide = (DIVD_W+1)'(pn) << od_reg;

    assign trial    = {rem_reg, dq_reg[DIVD_W-1]};
    assign q_bit    = trial >= {1'b0, ref_reg};
    assign rem_next = q_bit ? REF_W'(trial - {1'b0, ref_reg}) : trial[REF_W-1:0];
    assign dq_next  = {dq_reg[DIVD_W-2:0], q_bit};

    // quotient holds M in the upper bits and FRAC in the lower FRAC_W bits
    assign word = ({dq_reg[FRAC_W-1:0], 14'd0})
                + (WORD_W'(od_reg) << OD_SHIFT)
                + (WORD_W'(n_reg) << N_SHIFT)
                + WORD_W'(dq_reg[DIVD_W-1:FRAC_W]);

    always_comb
    begin
        status.bad      = (pclk_reg == '0) || (pclk_reg > VCO_MAX) || (ref_reg < REF_MIN_DIV);
        status.n_lo     = {1'b0, ref_reg} < n_lo_lim;
        status.n_hi     = {1'b0, ref_reg} >= n_hi_lim;
        status.od_lo    = vco < VCO_W'(VCO_MIN);
        status.od_hi    = vco > VCO_W'(VCO_MAX);
        status.div_last = cnt_reg == DCNT_W'(DIVD_W - 1);
        status.out_free = !out_valid_reg || res_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg       <= REF_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                ref_reg <= cfg_data;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            pclk_reg <= req_pclk;
            n_reg    <= N_INIT;
            od_reg   <= OD_INIT;
            err_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.set_err)
                err_reg <= 1'b1;
            if (cmd.n_step)
            begin
                if (status.n_lo)
                    n_reg <= n_reg - 1'b1;
                else if (status.n_hi)
                    n_reg <= n_reg + 1'b1;
            end
            if (cmd.od_step)
            begin
                if (status.od_lo)
                    od_reg <= od_reg + 1'b1;
                else if (status.od_hi)
                    od_reg <= od_reg - 1'b1;
            end
        end

        if (cmd.div_load)
        begin
            dq_reg  <= {prod_wide[PROD_W-1:0], {FRAC_W{1'b0}}};
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 1'b1;
        end

        if (cmd.out_load)
        begin
            if (err_reg)
            begin
                res_word <= '0;
                res_mult <= '0;
                res_ndiv <= '0;
                res_od   <= '0;
                res_frac <= '0;
            end
            else
            begin
                res_word <= word;
                res_mult <= dq_reg[DIVD_W-1:FRAC_W];
                res_ndiv <= NDIV_W'(n_reg);
                res_od   <= od_reg;
                res_frac <= dq_reg[FRAC_W-1:0];
            end
            res_err <= err_reg;
        end
    end

    assign res_valid = out_valid_reg;

endmodule

// File: hdl/frac_pll_setting_calc.sv
// Fractional PLL setting calculator, top level; uses fpsc_pkg, fpsc_ifs, fpsc_ctrl, fpsc_dp.
// A request passes through the range check, the N search (kN steps, 0..17), the OD
// search (kOD steps, 0..16) and the divider, which dominates; out-of-range requests
// go from the check straight to the result. One request is handled at a time;
// the next is taken the cycle after the result is registered.
// Reset: asynchronous, active low; ref_clk_khz returns to 33333.
module frac_pll_setting_calc (
    input  logic       clk,
    input  logic       rst_n,
    fpsc_cfg_if.sink   cfg,
    fpsc_req_if.sink   request,
    fpsc_res_if.source result
);
    import fpsc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;

    assign cfg.ready     = 1'b1;
    assign request.ready = in_ready;

    fpsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    fpsc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.ref_clk_khz),
        .req_pclk  (request.pixel_clk_khz),
        .res_ready (result.ready),
        .res_valid (result.valid),
        .res_word  (result.pll_word),
        .res_mult  (result.mult_int),
        .res_ndiv  (result.pre_div),
        .res_od    (result.out_div_exp),
        .res_frac  (result.frac_part),
        .res_err   (result.range_error)
    );

    // a held result is never overwritten
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result register overwritten while held");

    // no request transaction while the searches or the divider are busy
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !cmd.div_step && !cmd.n_step && !cmd.od_step)
        else $error("request taken while computation active");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.range_error |->
            result.pll_word == '0 && result.mult_int == '0 && result.pre_div == '0
            && result.out_div_exp == '0 && result.frac_part == '0)
        else $error("error result carries nonzero fields");

    a_ndiv_nz: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.range_error |-> result.pre_div != '0)
        else $error("valid result with zero input divider");

endmodule
